// ===== hdl/ach_pkg.sv =====
// ----------------------------------------------------------------------------
// ach_pkg
// Shared constants, types and the sample-to-code scaling function of the
// converter code histogram.
// ----------------------------------------------------------------------------
package ach_pkg;

    localparam int CODE_BITS       = 8;
    localparam int NUM_BINS        = 256;
    localparam int MAX_SAMPLE_BITS = 16;
    localparam int CFG_BITS        = 5;
    localparam int CNT_BITS        = 32;
    localparam int SUM_BITS        = 48;
    localparam int IN_DATA_BITS    = 16;
    localparam int IN_USER_BITS    = 2;
    localparam int OUT_DATA_BITS   = 168;

    localparam logic [CFG_BITS-1:0]  CONV_BITS_RESET = CFG_BITS'(8);
    localparam logic [CODE_BITS-1:0] MIN_CODE_EMPTY  = '1;
    localparam logic [CNT_BITS-1:0]  CNT_SAT         = '1;
    localparam logic [SUM_BITS-1:0]  SUM_SAT         = '1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic [CODE_BITS-1:0] scale_code(
        input logic [MAX_SAMPLE_BITS-1:0] raw,
        input logic [CFG_BITS-1:0]        bits
    );
        logic [CFG_BITS-1:0]                  b;
        logic [MAX_SAMPLE_BITS-1:0]           m;
        logic [MAX_SAMPLE_BITS+CODE_BITS-1:0] v;
        if (bits == '0)
            b = CFG_BITS'(1);
        else if (bits > CFG_BITS'(MAX_SAMPLE_BITS))
            b = CFG_BITS'(MAX_SAMPLE_BITS);
        else
            b = bits;
        m = raw & ((MAX_SAMPLE_BITS'(1) << b) - MAX_SAMPLE_BITS'(1));
        v = {{CODE_BITS{1'b0}}, m};
        if (b >= CFG_BITS'(CODE_BITS))
            v = v >> (b - CFG_BITS'(CODE_BITS));
        else
            v = v << (CFG_BITS'(CODE_BITS) - b);
        return v[CODE_BITS-1:0];
    endfunction

endpackage

// ===== hdl/ach_ctrl.sv =====
// ----------------------------------------------------------------------------
// ach_ctrl
// Item sequencer: takes one item, then runs its bin update once the
// output register can take the result.
// ----------------------------------------------------------------------------
module ach_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  ach_pkg::dp_status_t status,
    output ach_pkg::dp_cmd_t    cmd
);
    import ach_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/ach_datapath.sv =====
// ----------------------------------------------------------------------------
// ach_datapath
// Code scaling, bin memory read-modify-write, running statistics and the
// output register.
// ----------------------------------------------------------------------------
module ach_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ach_pkg::CFG_BITS-1:0]        cfg_wr_data,
    input  logic [ach_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    input  logic [ach_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
    input  ach_pkg::dp_cmd_t                    cmd,
    output ach_pkg::dp_status_t                 status,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ach_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import ach_pkg::*;

    logic [CNT_BITS-1:0]      bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]      bin_valid_reg;

    logic [CFG_BITS-1:0]      conv_bits_reg;
    logic                     op_reg;
    logic                     batch_reg;
    logic [CODE_BITS-1:0]     code_reg;
    logic [CNT_BITS-1:0]      rd_data_reg;
    logic                     rd_valid_reg;

    logic [CODE_BITS-1:0]     min_reg;
    logic [CODE_BITS-1:0]     max_reg;
    logic [CNT_BITS-1:0]      count_reg;
    logic [SUM_BITS-1:0]      sum_reg;
    logic [CNT_BITS-1:0]      peak_reg;

    logic                     m_valid_reg;
    logic [OUT_DATA_BITS-1:0] m_data_reg;

    logic [CODE_BITS-1:0]     code_in;
    logic [CNT_BITS-1:0]      cnt_old;
    logic [CNT_BITS-1:0]      cnt_inc;
    logic [CNT_BITS-1:0]      peak_base;
    logic [CODE_BITS-1:0]     min_next;
    logic [CODE_BITS-1:0]     max_next;
    logic [CNT_BITS-1:0]      count_next;
    logic [SUM_BITS-1:0]      sum_next;
    logic [CNT_BITS-1:0]      peak_next;
    logic [SUM_BITS:0]        sum_ext;
    logic [OUT_DATA_BITS-1:0] result;

    assign code_in = scale_code(s_axis_tdata, conv_bits_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            conv_bits_reg <= CONV_BITS_RESET;
        else if (cfg_wr_en)
            conv_bits_reg <= cfg_wr_data;
    end

    // bin memory: registered read at item accept, write on an add item's update
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            rd_data_reg <= bin_mem[code_in];
        if (cmd.exec && op_reg == OP_ADD)
            bin_mem[code_reg] <= cnt_inc;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= s_axis_tuser[0];
            batch_reg    <= s_axis_tuser[1];
            code_reg     <= code_in;
            rd_valid_reg <= bin_valid_reg[code_in];
        end
    end

    always_comb
    begin
        cnt_old    = rd_valid_reg ? rd_data_reg : '0;
        cnt_inc    = (cnt_old == CNT_SAT) ? cnt_old : cnt_old + CNT_BITS'(1);
        peak_base  = batch_reg ? '0 : peak_reg;
        peak_next  = (cnt_inc > peak_base) ? cnt_inc : peak_base;
        min_next   = (code_reg < min_reg) ? code_reg : min_reg;
        max_next   = (code_reg > max_reg) ? code_reg : max_reg;
        count_next = (count_reg == CNT_SAT) ? count_reg : count_reg + CNT_BITS'(1);
        sum_ext    = {1'b0, sum_reg} + (SUM_BITS+1)'(code_reg);
        sum_next   = sum_ext[SUM_BITS] ? SUM_SAT : sum_ext[SUM_BITS-1:0];
        if (op_reg == OP_CLEAR)
            result = {{SUM_BITS{1'b0}}, {CNT_BITS{1'b0}}, {CODE_BITS{1'b0}},
                      MIN_CODE_EMPTY, {CNT_BITS{1'b0}}, {CNT_BITS{1'b0}},
                      {CODE_BITS{1'b0}}};
        else
            result = {sum_next, count_next, max_next, min_next, peak_next,
                      cnt_inc, code_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            min_reg       <= MIN_CODE_EMPTY;
            max_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            peak_reg      <= '0;
        end
        else if (cmd.exec)
        begin
            if (op_reg == OP_CLEAR)
            begin
                bin_valid_reg <= '0;
                min_reg       <= MIN_CODE_EMPTY;
                max_reg       <= '0;
                count_reg     <= '0;
                sum_reg       <= '0;
                peak_reg      <= '0;
            end
            else
            begin
                bin_valid_reg[code_reg] <= 1'b1;
                min_reg                 <= min_next;
                max_reg                 <= max_next;
                count_reg               <= count_next;
                sum_reg                 <= sum_next;
                peak_reg                <= peak_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.exec)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            m_data_reg <= result;
    end

    assign status.out_free = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;

endmodule

// ===== hdl/adc_code_histogram_top.sv =====
// ----------------------------------------------------------------------------
// adc_code_histogram_top
// Code density histogram of converter samples with running statistics.
//
// Input stream: tdata carries the raw sample, tuser the command (add or
// clear) and the batch start flag. Output stream: one result item per input
// item with the code, its bin count, the batch peak and the min, max, count
// and sum since the last clear.
// cfg_wr_en/cfg_wr_data set the converter resolution; write only while idle.
// Per item, the bin memory read is registered at acceptance; the
// read-modify-write and statistics update then run once the output register
// is free, and load it. A new item is not accepted until the previous one
// has loaded the output register.
// A new item is accepted while a result waits in the output register; its
// update then holds until that result is taken.
// Reset (and a clear item) empties the histogram at once through per-bin
// valid flags; resolution resets to 8 bits.
// ----------------------------------------------------------------------------
module adc_code_histogram_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ach_pkg::CFG_BITS-1:0]        cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] raw_sample
    input  logic [ach_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // [0] command, [1] batch_start
    input  logic [ach_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] code, [39:8] bin_count, [71:40] batch_peak, [79:72] min_code,
    // [87:80] max_code, [119:88] sample_count, [167:120] sample_sum
    output logic [ach_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import ach_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ach_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    ach_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_load_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.exec))
        else $error("load and update issued together");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous item still in update");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_axis_tvalid)
        else $error("update did not present a result");

    a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
        else $error("update overwrote a pending result");

endmodule

// ===== tb/adc_code_histogram_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_code_histogram_checker
// Watches the configuration port and both streams of the code histogram.
// Every accepted input item updates a local copy of the bins and running
// statistics. The resulting record is queued, then compared field by field
// with the next output item. Counts mismatches and outstanding records.
// ----------------------------------------------------------------------------
module adc_code_histogram_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ach_pkg::CFG_BITS-1:0]        cfg_wr_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ach_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    input  logic [ach_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ach_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    output int                                  errors,
    output int                                  pending
);
    import ach_pkg::*;

    typedef struct packed {
        logic [SUM_BITS-1:0]  sample_sum;
        logic [CNT_BITS-1:0]  sample_count;
        logic [CODE_BITS-1:0] max_code;
        logic [CODE_BITS-1:0] min_code;
        logic [CNT_BITS-1:0]  batch_peak;
        logic [CNT_BITS-1:0]  bin_count;
        logic [CODE_BITS-1:0] code;
    } stats_t;

    logic [CFG_BITS-1:0]  resolution;
    logic [CNT_BITS-1:0]  hist_bins [NUM_BINS];
    logic [CODE_BITS-1:0] lo_code;
    logic [CODE_BITS-1:0] hi_code;
    logic [CNT_BITS-1:0]  n_samples;
    logic [SUM_BITS-1:0]  code_sum;
    logic [CNT_BITS-1:0]  peak;
    stats_t               expected_stats [$];

    function automatic logic [CODE_BITS-1:0] code_of(
        input logic [IN_DATA_BITS-1:0] raw,
        input logic [CFG_BITS-1:0]     res
    );
        int                  eff;
        logic [31:0]         kept;
        logic [31:0]         wide;
        eff = int'(res);
        if (eff < 1)
            eff = 1;
        if (eff > MAX_SAMPLE_BITS)
            eff = MAX_SAMPLE_BITS;
        kept = 32'(raw) & ((32'd1 << eff) - 32'd1);
        if (eff >= CODE_BITS)
            wide = kept >> (eff - CODE_BITS);
        else
            wide = kept << (CODE_BITS - eff);
        return wide[CODE_BITS-1:0];
    endfunction

    function automatic void wipe_histogram();
        for (int i = 0; i < NUM_BINS; i++)
            hist_bins[i] = '0;
        lo_code   = MIN_CODE_EMPTY;
        hi_code   = '0;
        n_samples = '0;
        code_sum  = '0;
        peak      = '0;
    endfunction

    function automatic stats_t apply_item(
        input logic                    cmd,
        input logic [IN_DATA_BITS-1:0] raw,
        input logic                    batch_start
    );
        stats_t r;
        r = '0;
        if (cmd == OP_CLEAR) begin
            wipe_histogram();
        end else begin
            r.code = code_of(raw, resolution);
            if (batch_start)
                peak = '0;
            r.bin_count = hist_bins[r.code];
            if (r.bin_count != CNT_SAT)
                r.bin_count++;
            hist_bins[r.code] = r.bin_count;
            if (r.bin_count > peak)
                peak = r.bin_count;
            if (r.code < lo_code)
                lo_code = r.code;
            if (r.code > hi_code)
                hi_code = r.code;
            if (n_samples != CNT_SAT)
                n_samples++;
            if (code_sum > SUM_SAT - SUM_BITS'(r.code))
                code_sum = SUM_SAT;
            else
                code_sum += SUM_BITS'(r.code);
        end
        r.batch_peak   = peak;
        r.min_code     = lo_code;
        r.max_code     = hi_code;
        r.sample_count = n_samples;
        r.sample_sum   = code_sum;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stats_t exp_r;
        stats_t act_r;
        int     n_err;
        int     n_pend;
        if (!rst_n) begin
            resolution = CONV_BITS_RESET;
            wipe_histogram();
            expected_stats.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            n_err  = errors;
            n_pend = pending;
            if (m_axis_tvalid && m_axis_tready) begin
                act_r = stats_t'(m_axis_tdata);
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, m_axis_tdata);
                    n_err++;
                end else begin
                    exp_r = expected_stats.pop_front();
                    n_pend--;
                    if (act_r.code != exp_r.code) begin
                        $display("%0t: code exp %0d got %0d", $time,
                                 exp_r.code, act_r.code);
                        n_err++;
                    end
                    if (act_r.bin_count != exp_r.bin_count) begin
                        $display("%0t: bin_count exp %0d got %0d", $time,
                                 exp_r.bin_count, act_r.bin_count);
                        n_err++;
                    end
                    if (act_r.batch_peak != exp_r.batch_peak) begin
                        $display("%0t: batch_peak exp %0d got %0d", $time,
                                 exp_r.batch_peak, act_r.batch_peak);
                        n_err++;
                    end
                    if (act_r.min_code != exp_r.min_code) begin
                        $display("%0t: min_code exp %0d got %0d", $time,
                                 exp_r.min_code, act_r.min_code);
                        n_err++;
                    end
                    if (act_r.max_code != exp_r.max_code) begin
                        $display("%0t: max_code exp %0d got %0d", $time,
                                 exp_r.max_code, act_r.max_code);
                        n_err++;
                    end
                    if (act_r.sample_count != exp_r.sample_count) begin
                        $display("%0t: sample_count exp %0d got %0d", $time,
                                 exp_r.sample_count, act_r.sample_count);
                        n_err++;
                    end
                    if (act_r.sample_sum != exp_r.sample_sum) begin
                        $display("%0t: sample_sum exp %0d got %0d", $time,
                                 exp_r.sample_sum, act_r.sample_sum);
                        n_err++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_stats.push_back(apply_item(s_axis_tuser[0], s_axis_tdata,
                                                    s_axis_tuser[1]));
                n_pend++;
            end
            if (cfg_wr_en)
                resolution = cfg_wr_data;
            errors  <= n_err;
            pending <= n_pend;
        end
    end

endmodule

// ===== tb/adc_code_histogram_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_code_histogram_top_tb
// Drives the code histogram with directed and random sample items under a
// range of converter resolutions, including out-of-range ones, with random
// gaps on the input and random stalls on the output. The checker beside the
// block predicts every result item; the verdict comes from its counts.
// ----------------------------------------------------------------------------
module adc_code_histogram_top_tb;
    import ach_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 102;
    localparam int NUM_PHASES   = 13;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_BITS-1:0]       cfg_wr_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata;
    logic [IN_USER_BITS-1:0]   s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    int                        errors;
    int                        pending;
    int                        cycles;
    int                        rx_hold;
    bit                        tx_gaps;
    bit                        rx_stalls;
    logic [IN_DATA_BITS-1:0]   hot_raw [4];
    logic [CFG_BITS-1:0]       res_plan [8] = '{5'd1, 5'd16, 5'd0, 5'd31,
                                                5'd8, 5'd17, 5'd4, 5'd12};

    adc_code_histogram_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    adc_code_histogram_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly none, some short, a few long
    function automatic int pick_idle(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        int g;
        if (!rst_n) begin
            rx_hold = 0;
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            g = pick_idle(rx_stalls);
            if (g > 0) begin
                rx_hold = g - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(
        input logic                    cmd,
        input logic [IN_DATA_BITS-1:0] raw,
        input logic                    batch_start
    );
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= {batch_start, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        g = pick_idle(tx_gaps);
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_resolution(input logic [CFG_BITS-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random();
        logic                    cmd;
        logic                    bs;
        logic [IN_DATA_BITS-1:0] raw;
        cmd = ($urandom_range(0, 99) < 3) ? OP_CLEAR : OP_ADD;
        bs  = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 1))
            raw = IN_DATA_BITS'($urandom_range(0, 65535));
        else
            raw = hot_raw[$urandom_range(0, 3)] ^ IN_DATA_BITS'($urandom_range(0, 3));
        send_item(cmd, raw, bs);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_gaps       = 1'b0;
        rx_stalls     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset resolution of 8 bits
        send_item(OP_ADD, 16'h0000, 1'b0);
        send_item(OP_ADD, 16'h00FF, 1'b0);
        send_item(OP_ADD, 16'hFFFF, 1'b0);
        send_item(OP_ADD, 16'hAB80, 1'b0);
        send_item(OP_ADD, 16'h0080, 1'b1);
        send_item(OP_ADD, 16'h0080, 1'b0);
        send_item(OP_ADD, 16'h0001, 1'b1);
        send_item(OP_CLEAR, 16'hFFFF, 1'b1);
        send_item(OP_ADD, 16'h0042, 1'b0);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_item(OP_CLEAR, 16'h0000, 1'b0);
        send_item(OP_ADD, 16'h0010, 1'b1);
        write_resolution(5'd16);
        send_item(OP_ADD, 16'hFFFF, 1'b0);
        send_item(OP_ADD, 16'h00FF, 1'b0);
        send_item(OP_ADD, 16'h8000, 1'b0);
        write_resolution(5'd1);
        send_item(OP_ADD, 16'h0001, 1'b0);
        send_item(OP_ADD, 16'hFFFE, 1'b0);
        write_resolution(5'd0);
        send_item(OP_ADD, 16'h0003, 1'b1);
        write_resolution(5'd31);
        send_item(OP_ADD, 16'hFFFF, 1'b0);
        send_item(OP_ADD, 16'h1234, 1'b0);
        write_resolution(5'd17);
        send_item(OP_ADD, 16'h7FFF, 1'b0);
        write_resolution(5'd3);
        send_item(OP_ADD, 16'hFFFD, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_resolution((p < 8) ? res_plan[p] : CFG_BITS'($urandom_range(0, 31)));
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            for (int h = 0; h < 4; h++)
                hot_raw[h] = IN_DATA_BITS'($urandom_range(0, 65535));
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ach_pkg.sv
hdl/ach_ctrl.sv
hdl/ach_datapath.sv
hdl/adc_code_histogram_top.sv
tb/adc_code_histogram_checker.sv
tb/adc_code_histogram_top_tb.sv
